/* sv/ppf_pkg.sv */
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the protocol / port / prefix packet filter.
// ----------------------------------------------------------------------------
package ppf_pkg;

    localparam int SLOT_W    = 4;
    localparam int SLOT_SPAN = 2 ** SLOT_W;
    localparam int ADDR_W    = 128;
    localparam int HALF_W    = 64;
    localparam int PROTO_W   = 8;
    localparam int PORT_W    = 16;
    localparam int PREFIX_W  = 8;
    localparam int QDEPTH    = 2;

    localparam logic [PREFIX_W-1:0] PREFIX_MAX = PREFIX_W'(ADDR_W);

    typedef enum logic [1:0] {
        OP_CLASSIFY    = 2'd0,
        OP_WRITE_PROTO = 2'd1,
        OP_WRITE_RANGE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        FAM_IPV4 = 2'd0,
        FAM_IPV6 = 2'd1
    } family_t;

    typedef enum logic [1:0] {
        CMD_CLASSIFY,
        CMD_PROTO,
        CMD_RANGE
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } back_state_t;

    // decoded work item passed from front to back
    typedef struct packed {
        cmd_kind_t             kind;
        logic [SLOT_W-1:0]     slot;
        logic                  enable;
        logic [PROTO_W-1:0]    proto;
        logic                  port_on;
        logic [PORT_W-1:0]     port;
        logic                  fam_ip;
        logic [ADDR_W-1:0]     addr;
        logic [PREFIX_W-1:0]   prefix;
    } cmd_t;

    typedef struct packed {
        logic [PROTO_W-1:0] number;
        logic               port_on;
        logic [PORT_W-1:0]  port;
    } proto_entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   base;
        logic [PREFIX_W-1:0] prefix;
    } range_entry_t;

endpackage

/* sv/ppf_ram.sv */
// ----------------------------------------------------------------------------
// ppf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ppf_front.sv */
// ----------------------------------------------------------------------------
// ppf_front
// Accepts items, decodes the opcode, drops items without effect and maps
// IPv4 destinations into the IPv6 space before queuing.
// ----------------------------------------------------------------------------
module ppf_front
    import ppf_pkg::*;
#(
    parameter int PROTO_RULES = 16,
    parameter int RANGE_RULES = 16
) (
    input  logic                push,
    output logic                full,
    input  logic [1:0]          opcode,
    input  logic [SLOT_W-1:0]   rule_slot,
    input  logic                entry_enable,
    input  logic [PROTO_W-1:0]  ip_protocol,
    input  logic                has_port,
    input  logic [PORT_W-1:0]   dest_port,
    input  logic [1:0]          addr_family,
    input  logic [HALF_W-1:0]   addr_upper,
    input  logic [HALF_W-1:0]   addr_lower,
    input  logic [PREFIX_W-1:0] prefix_bits,
    output logic                q_push,
    input  logic                q_full,
    output cmd_t                q_cmd
);

    logic keep;

    assign full = q_full;

    always_comb
    begin
        q_cmd.kind    = CMD_CLASSIFY;
        q_cmd.slot    = rule_slot;
        q_cmd.enable  = entry_enable;
        q_cmd.proto   = ip_protocol;
        q_cmd.port_on = has_port;
        q_cmd.port    = dest_port;
        q_cmd.fam_ip  = 1'b0;
        q_cmd.addr    = {addr_upper, addr_lower};
        q_cmd.prefix  = (prefix_bits > PREFIX_MAX) ? PREFIX_MAX : prefix_bits;
        keep          = 1'b0;

        case (opcode_t'(opcode))
            OP_CLASSIFY:
            begin
                keep = 1'b1;
                case (family_t'(addr_family))
                    FAM_IPV6:
                    begin
                        q_cmd.fam_ip = 1'b1;
                    end
                    FAM_IPV4:
                    begin
                        // ::ffff:a.b.c.d
                        q_cmd.fam_ip = 1'b1;
                        q_cmd.addr   = {{HALF_W{1'b0}}, 32'h0000_ffff, addr_lower[31:0]};
                    end
                    default:
                    begin
                        q_cmd.fam_ip = 1'b0;
                    end
                endcase
            end
            OP_WRITE_PROTO:
            begin
                q_cmd.kind = CMD_PROTO;
                keep       = (32'(rule_slot) < PROTO_RULES);
            end
            OP_WRITE_RANGE:
            begin
                q_cmd.kind = CMD_RANGE;
                keep       = (32'(rule_slot) < RANGE_RULES);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // unused opcodes and writes beyond the table are dropped on transfer
    assign q_push = push && !q_full && keep;

endmodule

/* sv/ppf_queue.sv */
// ----------------------------------------------------------------------------
// ppf_queue
// Short queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module ppf_queue
    import ppf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t wdata,
    input  logic pop,
    output logic empty,
    output cmd_t rdata
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          data_reg [QDEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = data_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == AW'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == AW'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wptr_reg] <= wdata;
        end
    end

endmodule

/* sv/ppf_back.sv */
// ----------------------------------------------------------------------------
// ppf_back
// Applies rule writes and classifies headers by scanning both rule memories,
// one entry of each per cycle, into an output result register.
// ----------------------------------------------------------------------------
module ppf_back
    import ppf_pkg::*;
#(
    parameter int PROTO_RULES = 16,
    parameter int RANGE_RULES = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    output logic q_pop,
    input  cmd_t q_cmd,
    output logic res_empty,
    input  logic res_pop,
    output logic allowed,
    output logic [(PROTO_RULES < SLOT_SPAN ? PROTO_RULES : SLOT_SPAN)-1:0] proto_valid,
    output logic [$clog2((PROTO_RULES < SLOT_SPAN ? PROTO_RULES : SLOT_SPAN) + 1)-1:0]
                 proto_cnt,
    output logic [(RANGE_RULES < SLOT_SPAN ? RANGE_RULES : SLOT_SPAN)-1:0] range_valid,
    output logic [$clog2((RANGE_RULES < SLOT_SPAN ? RANGE_RULES : SLOT_SPAN) + 1)-1:0]
                 range_cnt
);

    localparam int PD   = (PROTO_RULES < SLOT_SPAN) ? PROTO_RULES : SLOT_SPAN;
    localparam int RD   = (RANGE_RULES < SLOT_SPAN) ? RANGE_RULES : SLOT_SPAN;
    localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
    localparam int RAW  = (RD > 1) ? $clog2(RD) : 1;
    localparam int PCW  = $clog2(PD + 1);
    localparam int RCW  = $clog2(RD + 1);
    localparam int SCAN = (PD > RD) ? PD : RD;
    localparam int SW   = (SCAN > 1) ? $clog2(SCAN) : 1;
    localparam int PEW  = $bits(proto_entry_t);
    localparam int REW  = $bits(range_entry_t);

    back_state_t   state_reg, state_next;
    logic [PD-1:0] pvalid_reg, pvalid_next;
    logic [RD-1:0] rvalid_reg, rvalid_next;
    logic [PCW-1:0] pcnt_reg, pcnt_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic          res_vld_reg, res_vld_next;
    logic          chk_vld_reg, chk_vld_next;

    cmd_t          hdr_reg, hdr_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW-1:0] chk_idx_reg, chk_idx_next;
    logic          p_hit_reg, p_hit_next;
    logic          r_hit_reg, r_hit_next;
    logic          hold_reg, hold_next;
    logic          allowed_reg, allowed_next;

    logic           p_we, r_we, rd_en;
    logic [PAW-1:0] p_waddr;
    logic [RAW-1:0] r_waddr;
    logic [PEW-1:0] p_rdata;
    logic [REW-1:0] r_rdata;
    proto_entry_t   p_wentry, p_entry;
    range_entry_t   r_wentry, r_entry;
    logic           p_in, r_in;
    logic           p_hit_now, r_hit_now;
    logic [ADDR_W-1:0] r_mask;

    assign p_waddr = PAW'(q_cmd.slot);
    assign r_waddr = RAW'(q_cmd.slot);

    assign p_wentry.number  = q_cmd.proto;
    assign p_wentry.port_on = q_cmd.port_on;
    assign p_wentry.port    = q_cmd.port;
    assign r_wentry.base    = q_cmd.addr;
    assign r_wentry.prefix  = q_cmd.prefix;

    ppf_ram #(
        .WIDTH(PEW),
        .DEPTH(PD)
    ) u_proto_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wentry),
        .re    (rd_en),
        .raddr (idx_reg[PAW-1:0]),
        .rdata (p_rdata)
    );

    ppf_ram #(
        .WIDTH(REW),
        .DEPTH(RD)
    ) u_range_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wentry),
        .re    (rd_en),
        .raddr (idx_reg[RAW-1:0]),
        .rdata (r_rdata)
    );

    // compare of the entry read in the previous cycle
    always_comb
    begin
        p_entry   = proto_entry_t'(p_rdata);
        r_entry   = range_entry_t'(r_rdata);
        p_in      = ({1'b0, chk_idx_reg} < (SW + 1)'(PD));
        r_in      = ({1'b0, chk_idx_reg} < (SW + 1)'(RD));
        r_mask    = ~({ADDR_W{1'b1}} >> r_entry.prefix);
        p_hit_now = chk_vld_reg && p_in && pvalid_reg[chk_idx_reg[PAW-1:0]]
                    && (p_entry.number == hdr_reg.proto)
                    && (!p_entry.port_on || !hdr_reg.port_on
                        || (p_entry.port == hdr_reg.port));
        r_hit_now = chk_vld_reg && r_in && rvalid_reg[chk_idx_reg[RAW-1:0]]
                    && (((hdr_reg.addr ^ r_entry.base) & r_mask) == '0);
    end

    always_comb
    begin
        state_next   = state_reg;
        pvalid_next  = pvalid_reg;
        rvalid_next  = rvalid_reg;
        pcnt_next    = pcnt_reg;
        rcnt_next    = rcnt_reg;
        res_vld_next = res_vld_reg;
        chk_vld_next = 1'b0;
        hdr_next     = hdr_reg;
        idx_next     = idx_reg;
        chk_idx_next = chk_idx_reg;
        p_hit_next   = p_hit_reg;
        r_hit_next   = r_hit_reg;
        hold_next    = hold_reg;
        allowed_next = allowed_reg;
        q_pop        = 1'b0;
        p_we         = 1'b0;
        r_we         = 1'b0;
        rd_en        = 1'b0;

        if (chk_vld_reg)
        begin
            p_hit_next = p_hit_reg | p_hit_now;
            r_hit_next = r_hit_reg | r_hit_now;
        end

        if (res_pop && res_vld_reg)
        begin
            res_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_PROTO:
                        begin
                            // a disable keeps the data and drops only the valid bit
                            p_we                 = q_cmd.enable;
                            pvalid_next[p_waddr] = q_cmd.enable;
                            if (q_cmd.enable && !pvalid_reg[p_waddr])
                            begin
                                pcnt_next = pcnt_reg + 1'b1;
                            end
                            else if (!q_cmd.enable && pvalid_reg[p_waddr])
                            begin
                                pcnt_next = pcnt_reg - 1'b1;
                            end
                        end
                        CMD_RANGE:
                        begin
                            r_we                 = q_cmd.enable;
                            rvalid_next[r_waddr] = q_cmd.enable;
                            if (q_cmd.enable && !rvalid_reg[r_waddr])
                            begin
                                rcnt_next = rcnt_reg + 1'b1;
                            end
                            else if (!q_cmd.enable && rvalid_reg[r_waddr])
                            begin
                                rcnt_next = rcnt_reg - 1'b1;
                            end
                        end
                        CMD_CLASSIFY:
                        begin
                            hdr_next = q_cmd;
                            if (pcnt_reg == '0 && rcnt_reg == '0)
                            begin
                                // empty rule set lets everything through
                                hold_next  = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                p_hit_next = 1'b0;
                                r_hit_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en        = 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = idx_reg;
                if (idx_reg == SW'(SCAN - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                hold_next  = (p_hit_reg | p_hit_now)
                             | ((rcnt_reg != '0) && hdr_reg.fam_ip
                                && (r_hit_reg | r_hit_now));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_vld_reg || res_pop)
                begin
                    res_vld_next = 1'b1;
                    allowed_next = hold_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pvalid_reg  <= '0;
            rvalid_reg  <= '0;
            pcnt_reg    <= '0;
            rcnt_reg    <= '0;
            res_vld_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pvalid_reg  <= pvalid_next;
            rvalid_reg  <= rvalid_next;
            pcnt_reg    <= pcnt_next;
            rcnt_reg    <= rcnt_next;
            res_vld_reg <= res_vld_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg     <= hdr_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        p_hit_reg   <= p_hit_next;
        r_hit_reg   <= r_hit_next;
        hold_reg    <= hold_next;
        allowed_reg <= allowed_next;
    end

    assign res_empty   = !res_vld_reg;
    assign allowed     = allowed_reg;
    assign proto_valid = pvalid_reg;
    assign proto_cnt   = pcnt_reg;
    assign range_valid = rvalid_reg;
    assign range_cnt   = rcnt_reg;

endmodule

/* sv/protocol_port_prefix_filter.sv */
// ----------------------------------------------------------------------------
// protocol_port_prefix_filter
// Packet access filter with a protocol/port rule table and a prefix range table.
// ----------------------------------------------------------------------------
// Items enter through a push/full queue port and are decoded by the front into
// a two-entry queue; the back applies rule writes and classifies headers. A rule
// write is applied as the back pops it and gives no result. In the back a classify
// item is popped, then both rule memories (depths P and R, at most 16 each, the
// reach of rule_slot) are scanned one entry per cycle through their single read
// port, then the last compare is finished, and the result register is loaded when
// it is empty or being popped. With no valid rule in either table a classify item
// skips the scan and is allowed. Results wait in an output register read through
// empty/pop while the front keeps queuing items.
// ----------------------------------------------------------------------------
module protocol_port_prefix_filter
    import ppf_pkg::*;
#(
    parameter int PROTO_RULES = 16,
    parameter int RANGE_RULES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          opcode,
    input  logic [SLOT_W-1:0]   rule_slot,
    input  logic                entry_enable,
    input  logic [PROTO_W-1:0]  ip_protocol,
    input  logic                has_port,
    input  logic [PORT_W-1:0]   dest_port,
    input  logic [1:0]          addr_family,
    input  logic [HALF_W-1:0]   addr_upper,
    input  logic [HALF_W-1:0]   addr_lower,
    input  logic [PREFIX_W-1:0] prefix_bits,
    output logic                empty,
    input  logic                pop,
    output logic                allowed
);

    localparam int PD  = (PROTO_RULES < SLOT_SPAN) ? PROTO_RULES : SLOT_SPAN;
    localparam int RD  = (RANGE_RULES < SLOT_SPAN) ? RANGE_RULES : SLOT_SPAN;
    localparam int PCW = $clog2(PD + 1);
    localparam int RCW = $clog2(RD + 1);

    logic           q_push, q_full, q_pop, q_empty;
    cmd_t           q_wcmd, q_rcmd;
    logic [PD-1:0]  proto_valid;
    logic [RD-1:0]  range_valid;
    logic [PCW-1:0] proto_cnt;
    logic [RCW-1:0] range_cnt;

    ppf_front #(
        .PROTO_RULES(PROTO_RULES),
        .RANGE_RULES(RANGE_RULES)
    ) u_front (
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .rule_slot    (rule_slot),
        .entry_enable (entry_enable),
        .ip_protocol  (ip_protocol),
        .has_port     (has_port),
        .dest_port    (dest_port),
        .addr_family  (addr_family),
        .addr_upper   (addr_upper),
        .addr_lower   (addr_lower),
        .prefix_bits  (prefix_bits),
        .q_push       (q_push),
        .q_full       (q_full),
        .q_cmd        (q_wcmd)
    );

    ppf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wcmd),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rcmd)
    );

    ppf_back #(
        .PROTO_RULES(PROTO_RULES),
        .RANGE_RULES(RANGE_RULES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_cmd       (q_rcmd),
        .res_empty   (empty),
        .res_pop     (pop),
        .allowed     (allowed),
        .proto_valid (proto_valid),
        .proto_cnt   (proto_cnt),
        .range_valid (range_valid),
        .range_cnt   (range_cnt)
    );

    // valid-entry counters must track the valid bits they summarize
    a_proto_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(proto_cnt) == $countones(proto_valid))
        else $error("protocol rule count out of step with valid bits");

    a_range_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(range_cnt) == $countones(range_valid))
        else $error("range rule count out of step with valid bits");

    // the back only takes from the queue when something is there
    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty item queue");

endmodule
